// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition on one edge implies a condition on the next edge
`define ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- sv/lcdsmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcdsmt_pkg;

    // Video modes in the standard status encoding
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    // Frame geometry
    localparam logic [8:0] VISIBLE_LINES  = 9'd144;
    localparam logic [8:0] TOTAL_LINES    = 9'd154;
    localparam logic [8:0] LEN_OAM        = 9'd80;
    localparam logic [8:0] LEN_XFER       = 9'd172;
    localparam logic [8:0] LEN_HBLANK     = 9'd204;
    localparam logic [8:0] LEN_LINE       = 9'd456;
    localparam logic [8:0] SCREEN_COLUMNS = 9'd160;

    // Register map indexes
    localparam logic [1:0] REG_HBLANK_EN = 2'd0;
    localparam logic [1:0] REG_LYC_EN    = 2'd1;
    localparam logic [1:0] REG_LYC       = 2'd2;

    typedef struct packed {
        mode_t      mode;
        logic [8:0] dot;
        logic [7:0] line;
        logic       match;
    } state_t;

    typedef struct packed {
        logic       hblank_en;
        logic       lyc_en;
        logic [7:0] compare;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] line;
        logic [8:0] dot;
        logic       hreq;
        logic       vreq;
        logic       sreq;
        logic       match;
        logic       strobe;
        logic [7:0] column;
    } res_t;

    // Length of each mode in dots
    function automatic logic [8:0] mode_len(mode_t m);
        logic [8:0] len;
        unique case (m)
            MODE_OAM:    len = LEN_OAM;
            MODE_XFER:   len = LEN_XFER;
            MODE_HBLANK: len = LEN_HBLANK;
            MODE_VBLANK: len = LEN_LINE;
            default:     len = LEN_LINE;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- sv/lcdsmt_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one dot tick
module lcdsmt_step (
    input  lcdsmt_pkg::state_t cur,
    input  logic               tick,
    input  lcdsmt_pkg::cfg_t   cfg,
    output lcdsmt_pkg::state_t nxt,
    output lcdsmt_pkg::res_t   res
);
    import lcdsmt_pkg::*;

    logic [8:0] dot_inc;
    logic [8:0] line_inc;
    logic       mode_end;
    logic       strobe;
    logic       hreq;
    logic       vreq;
    logic       sreq;
    logic       lyc_hit;

    assign dot_inc  = cur.dot + 9'd1;
    assign line_inc = {1'b0, cur.line} + 9'd1;
    assign mode_end = (dot_inc >= mode_len(cur.mode));
    assign lyc_hit  = (cur.line == cfg.compare);
    assign strobe   = tick && (cur.mode == MODE_XFER) && (cur.dot < SCREEN_COLUMNS);

    always_comb
    begin
        nxt  = cur;
        hreq = 1'b0;
        vreq = 1'b0;
        sreq = 1'b0;
        if (tick)
        begin
            nxt.dot = dot_inc;
            if (mode_end)
            begin
                nxt.dot = '0;
                unique case (cur.mode)
                    MODE_OAM:
                    begin
                        nxt.mode = MODE_XFER;
                    end
                    MODE_XFER:
                    begin
                        nxt.mode  = MODE_HBLANK;
                        nxt.match = lyc_hit;
                        hreq      = cfg.hblank_en;
                        sreq      = cfg.lyc_en && lyc_hit;
                    end
                    MODE_HBLANK:
                    begin
                        // counter overflow ends the frame
                        if (line_inc[8])
                        begin
                            nxt.line = '0;
                            nxt.mode = MODE_OAM;
                        end
                        else
                        begin
                            nxt.line = line_inc[7:0];
                            if (line_inc == VISIBLE_LINES)
                            begin
                                nxt.mode = MODE_VBLANK;
                                vreq     = 1'b1;
                            end
                            else
                            begin
                                nxt.mode = MODE_OAM;
                            end
                        end
                    end
                    MODE_VBLANK:
                    begin
                        if (line_inc == TOTAL_LINES || line_inc[8])
                        begin
                            nxt.line = '0;
                            nxt.mode = MODE_OAM;
                        end
                        else
                        begin
                            nxt.line = line_inc[7:0];
                        end
                    end
                    default:
                    begin
                        nxt.mode = MODE_OAM;
                    end
                endcase
            end
        end
    end

    // Result reports the state after this tick; the pixel strobe and column come from the state before it
    always_comb
    begin
        res.mode   = nxt.mode;
        res.line   = nxt.line;
        res.dot    = nxt.dot;
        res.hreq   = hreq;
        res.vreq   = vreq;
        res.sreq   = sreq;
        res.match  = nxt.match;
        res.strobe = strobe;
        res.column = strobe ? cur.dot[7:0] : 8'd0;
    end

endmodule

`default_nettype wire

// ----- sv/lcd_scan_mode_timing.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                        Moves
// input     in_valid / in_ready            one dot tick per transfer
// output    out_valid / out_ready          mode, counters, requests, pixel strobe
// config    psel/penable/pwrite/paddr      register write and readback, pready tied high
//
// One tick per clock unless stalled: the timing state updates in the cycle a tick is
// accepted and the result lands in the output register at that same edge.
// The rate is set by the single output register: a new tick is taken whenever
// that register is empty or being drained in the same cycle.
// Reset clears the timing state to line 0, object scan, dot 0, and empties the output.
// A stalled output holds its result and stalls the input.
module lcd_scan_mode_timing (
    input  logic        clk,
    input  logic        rst_n,
    // tick channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        tick,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  video_mode,
    output logic [7:0]  current_line,
    output logic [8:0]  dot_in_mode,
    output logic        hblank_request,
    output logic        vblank_request,
    output logic        stat_request,
    output logic        coincidence_flag,
    output logic        pixel_strobe,
    output logic [7:0]  pixel_column,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdsmt_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    res_t       res_reg;
    res_t       res_next;
    cfg_t       cfg_reg;
    logic       out_valid_reg;
    logic       in_xfer;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign reg_idx  = paddr[3:2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_HBLANK_EN: cfg_reg.hblank_en <= pwdata[0];
                REG_LYC_EN:    cfg_reg.lyc_en    <= pwdata[0];
                REG_LYC:       cfg_reg.compare   <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_HBLANK_EN: prdata = {31'd0, cfg_reg.hblank_en};
            REG_LYC_EN:    prdata = {31'd0, cfg_reg.lyc_en};
            REG_LYC:       prdata = {24'd0, cfg_reg.compare};
            default:       prdata = 32'd0;
        endcase
    end

    lcdsmt_step u_step (
        .cur  (state_reg),
        .tick (tick),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode  <= MODE_OAM;
            state_reg.dot   <= '0;
            state_reg.line  <= '0;
            state_reg.match <= 1'b0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign video_mode       = res_reg.mode;
    assign current_line     = res_reg.line;
    assign dot_in_mode      = res_reg.dot;
    assign hblank_request   = res_reg.hreq;
    assign vblank_request   = res_reg.vreq;
    assign stat_request     = res_reg.sreq;
    assign coincidence_flag = res_reg.match;
    assign pixel_strobe     = res_reg.strobe;
    assign pixel_column     = res_reg.column;

endmodule

`default_nettype wire

// ----- sv/lcdsmt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Port-level checks of the scan timing block
module lcdsmt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  video_mode,
    input  logic [7:0]  current_line,
    input  logic [8:0]  dot_in_mode,
    input  logic        hblank_request,
    input  logic        vblank_request,
    input  logic        stat_request,
    input  logic        coincidence_flag,
    input  logic        pixel_strobe,
    input  logic [7:0]  pixel_column
);
    import lcdsmt_pkg::*;

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(dot_in_mode) && $stable(current_line) && $stable(video_mode), "stalled result changed")

    // Pixels only come out during transfer, within the visible columns
    `ASSERT_CLK(a_strobe_xfer, out_valid && pixel_strobe |-> video_mode == MODE_XFER && {1'b0, pixel_column} < SCREEN_COLUMNS, "pixel strobe outside transfer")

    // Vblank request marks the first dot of the first blank line
    `ASSERT_CLK(a_vblank_entry, out_valid && vblank_request |-> video_mode == MODE_VBLANK && {1'b0, current_line} == VISIBLE_LINES && dot_in_mode == 9'd0, "vblank request out of place")

    // Hblank and status requests fire only on entry to hblank
    `ASSERT_CLK(a_hblank_entry, out_valid && (hblank_request || stat_request) |-> video_mode == MODE_HBLANK && dot_in_mode == 9'd0, "hblank or status request out of place")

    // A status request implies the latched match
    `ASSERT_CLK(a_stat_match, out_valid && stat_request |-> coincidence_flag, "status request without coincidence")

endmodule

bind lcd_scan_mode_timing lcdsmt_checker u_lcdsmt_checker (.*);

`default_nettype wire
